// ===== rtl/cbm_pkg.sv =====
// Shared types and constants of the cartridge bank mapper.
// No dependencies; used by the interface, the mapping logic and the top level.
package cbm_pkg;

  // Sizing defaults for the top-level parameters
  localparam int unsigned MaxRomBanksDefault = 128;
  localparam int unsigned MaxRamBanksDefault = 4;

  // Fixed field widths
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned OffsetW  = 22;
  localparam int unsigned RomSelW  = 7;   // MBC1 high:low bank select
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Mapper kinds
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_MBC1  = 2'd1,
    KIND_MBC2  = 2'd2
  } kind_e;

  // Result targets
  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_ROM     = 2'd1,
    TGT_RAM     = 2'd2,
    TGT_RAM_OFF = 2'd3
  } target_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAPPER_KIND    = 2'd0,
    CFG_ROM_BANK_COUNT = 2'd1,
    CFG_RAM_BANK_COUNT = 2'd2,
    CFG_RAM_CAPABLE    = 2'd3
  } cfg_idx_e;

  // Bus access
  typedef struct packed {
    logic             operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } req_t;

  // Mapped result
  typedef struct packed {
    logic [1:0]         target;
    logic [OffsetW-1:0] physical_offset;
  } rsp_t;

  // Configuration registers
  typedef struct packed {
    logic [1:0] mapper_kind;
    logic [7:0] rom_bank_count;
    logic [2:0] ram_bank_count;
    logic       ram_capable;
  } cfg_t;

  // Bank controller registers
  typedef struct packed {
    logic       ram_enable;
    logic [4:0] low_bank;
    logic [1:0] high_bank;
    logic       bank_mode;
    logic [3:0] mbc2_bank;
  } bank_t;

endpackage

// ===== rtl/cbm_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per transaction.
// Payload types come from cbm_pkg.
interface cbm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/cbm_map.sv =====
// Combinational bank mapping: result of one access and next bank registers.
// Depends on cbm_pkg.
module cbm_map #(
  parameter int unsigned MAX_ROM_BANKS = cbm_pkg::MaxRomBanksDefault,
  parameter int unsigned MAX_RAM_BANKS = cbm_pkg::MaxRamBanksDefault
) (
  input  cbm_pkg::cfg_t  cfg_i,
  input  cbm_pkg::bank_t bank_i,
  input  cbm_pkg::req_t  req_i,
  output cbm_pkg::rsp_t  rsp_o,
  output cbm_pkg::bank_t bank_o
);
  import cbm_pkg::*;

  localparam logic [7:0] MaxRom = 8'(MAX_ROM_BANKS);
  localparam logic [2:0] MaxRam = 3'(MAX_RAM_BANKS);

  logic [7:0]         eff_rom;
  logic [7:0]         eff_rom_m1;
  logic [RomSelW-1:0] mask;
  logic [RomSelW-1:0] sel;
  logic [RomSelW-1:0] rom_bank;
  logic [2:0]         ram_cnt;
  logic [2:0]         ram_cnt_m1;
  logic [1:0]         ram_bank;
  logic               nib_a;

  // Clamp the ROM bank count and form the select mask
  always_comb begin
    eff_rom = cfg_i.rom_bank_count;
    if (eff_rom < 8'd2) eff_rom = 8'd2;
    if (eff_rom > MaxRom) eff_rom = MaxRom;
    eff_rom_m1 = eff_rom - 8'd1;
    mask       = eff_rom_m1[RomSelW-1:0];
  end

  // Switchable ROM bank, with the MBC1 mode-0 skip of 0x20/0x40/0x60
  always_comb begin
    rom_bank = RomSelW'(1);
    sel      = '0;
    case (cfg_i.mapper_kind)
      KIND_MBC1: begin
        sel = bank_i.bank_mode ? {2'b00, bank_i.low_bank}
                               : {bank_i.high_bank, bank_i.low_bank};
        rom_bank = sel & mask;
        if (rom_bank < RomSelW'(2)) begin
          rom_bank = RomSelW'(1);
        end else if (!bank_i.bank_mode &&
                     (rom_bank == 7'h20 || rom_bank == 7'h40 || rom_bank == 7'h60)) begin
          rom_bank = rom_bank + RomSelW'(1);
        end
      end
      KIND_MBC2: begin
        sel      = {3'b000, bank_i.mbc2_bank};
        rom_bank = sel & mask;
        if (rom_bank < RomSelW'(2)) rom_bank = RomSelW'(1);
      end
      default: begin
        sel      = '0;
        rom_bank = RomSelW'(1);
      end
    endcase
  end

  // RAM bank: MBC1 mode 1 only, with a RAM-capable cart of several banks
  always_comb begin
    ram_cnt = (cfg_i.ram_bank_count > MaxRam) ? MaxRam : cfg_i.ram_bank_count;
    ram_cnt_m1 = ram_cnt - 3'd1;
    ram_bank   = 2'b00;
    if (cfg_i.mapper_kind == KIND_MBC1 && cfg_i.ram_capable &&
        ram_cnt > 3'd1 && bank_i.bank_mode) begin
      ram_bank = bank_i.high_bank;
      if ({1'b0, ram_bank} >= ram_cnt) ram_bank = ram_bank & ram_cnt_m1[1:0];
    end
  end

  // Access decode and register writes
  always_comb begin
    nib_a  = (req_i.write_data[3:0] == 4'hA);
    bank_o = bank_i;
    rsp_o.target          = TGT_NONE;
    rsp_o.physical_offset = '0;
    if (!req_i.address[15]) begin
      if (req_i.operation) begin
        case (cfg_i.mapper_kind)
          KIND_MBC1: begin
            case (req_i.address[14:13])
              2'b11:   bank_o.bank_mode  = (req_i.write_data != '0);
              2'b10:   bank_o.high_bank  = req_i.write_data[1:0];
              2'b01:   bank_o.low_bank   = req_i.write_data[4:0];
              default: bank_o.ram_enable = nib_a && (cfg_i.ram_bank_count != 3'd0);
            endcase
          end
          KIND_MBC2: begin
            if (!req_i.address[14]) begin
              if (req_i.address[13]) begin
                if (req_i.address[8]) bank_o.mbc2_bank = req_i.write_data[3:0];
              end else if (!req_i.address[8]) begin
                bank_o.ram_enable = nib_a;
              end
            end
          end
          default: bank_o = bank_i;
        endcase
      end else begin
        rsp_o.target = TGT_ROM;
        rsp_o.physical_offset = req_i.address[14]
            ? OffsetW'({rom_bank, req_i.address[13:0]})
            : OffsetW'(req_i.address);
      end
    end else if (req_i.address[15:13] == 3'b101) begin
      if (bank_i.ram_enable) begin
        rsp_o.target = TGT_RAM;
        rsp_o.physical_offset = OffsetW'({eff_rom, 14'b0})
                              + OffsetW'({ram_bank, req_i.address[12:0]});
      end else begin
        rsp_o.target = TGT_RAM_OFF;
      end
    end
  end

endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: channels, config registers, pipeline.
// Depends on cbm_pkg, cbm_stream_if and cbm_map.
//
// Usage: req_i carries one CPU bus access per transaction (operation,
// address, write_data); rsp_o returns exactly one result per access, in
// order (target, physical_offset into the ROM image followed by RAM).
// Writes below 0x8000 update the MBC1/MBC2 bank registers and return
// target none; reads map to ROM, RAM, RAM-disabled or none.
// Pipeline: the request transaction loads the input register; the mapping
// is then loaded into the result register, which drives result valid.
// Throughput is one access per cycle while the receiver does not stall;
// the bank registers are updated as an access leaves the input register,
// so the next access already sees the new banks.
// When the receiver stalls, the result register holds and the input
// register takes one more access; after that req_i.ready drops.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the next edge.
// The user must make them while the block is idle; no logic enforces this.
// Reset: all bank registers clear, config returns to plain ROM, two ROM
// banks, no RAM; both pipeline registers empty.
module cartridge_bank_mapper #(
  parameter int unsigned MAX_ROM_BANKS = cbm_pkg::MaxRomBanksDefault,
  parameter int unsigned MAX_RAM_BANKS = cbm_pkg::MaxRamBanksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  cbm_stream_if.sink                   req_i,
  cbm_stream_if.source                 rsp_o
);
  import cbm_pkg::*;

  cfg_t  cfg_q;
  bank_t bank_q;
  bank_t bank_d;
  logic  s1_valid_q;
  req_t  s1_req_q;
  logic  rsp_valid_q;
  rsp_t  rsp_q;
  rsp_t  map_rsp;
  logic  advance;
  logic  req_accept;

  // Handshake
  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign req_accept  = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mapper_kind    <= KIND_PLAIN;
      cfg_q.rom_bank_count <= 8'd2;
      cfg_q.ram_bank_count <= 3'd0;
      cfg_q.ram_capable    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAPPER_KIND:    cfg_q.mapper_kind    <= cfg_wdata_i[1:0];
        CFG_ROM_BANK_COUNT: cfg_q.rom_bank_count <= cfg_wdata_i;
        CFG_RAM_BANK_COUNT: cfg_q.ram_bank_count <= cfg_wdata_i[2:0];
        CFG_RAM_CAPABLE:    cfg_q.ram_capable    <= cfg_wdata_i[0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // Mapping logic between input and result registers
  cbm_map #(
    .MAX_ROM_BANKS(MAX_ROM_BANKS),
    .MAX_RAM_BANKS(MAX_RAM_BANKS)
  ) u_map (
    .cfg_i  (cfg_q),
    .bank_i (bank_q),
    .req_i  (s1_req_q),
    .rsp_o  (map_rsp),
    .bank_o (bank_d)
  );

  // Control state: valid flags and bank registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      bank_q      <= '0;
    end else begin
      if (req_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        rsp_valid_q <= s1_valid_q;
        if (s1_valid_q) bank_q <= bank_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_accept) s1_req_q <= req_i.payload;
    if (advance && s1_valid_q) rsp_q <= map_rsp;
  end

  // A full input register behind a stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && rsp_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request accepted with both stages full");

  // A stalled result register keeps its content
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> rsp_valid_q && rsp_q == $past(rsp_q))
    else $error("stalled result changed");

  // Non-memory targets carry a zero offset
  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.target == TGT_NONE || rsp_q.target == TGT_RAM_OFF)
    |-> rsp_q.physical_offset == '0)
    else $error("nonzero offset on unmapped result");

  // RAM offsets lie past the smallest ROM image
  a_ram_past_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.target == TGT_RAM |-> rsp_q.physical_offset >= OffsetW'(32'h8000))
    else $error("RAM offset inside ROM image");

endmodule

// ===== tb/sv/tb_cartridge_bank_mapper.sv =====
// Self-checking testbench for cartridge_bank_mapper: directed and random bus traffic.
// Depends on cbm_pkg, cbm_stream_if, cbm_map and the cartridge_bank_mapper RTL; needs no other files.
// An in-bench bank model predicts each result; results are compared in order.
module tb_cartridge_bank_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  cbm_stream_if #(.T(req_t)) req_if ();
  cbm_stream_if #(.T(rsp_t)) rsp_if ();

  cartridge_bank_mapper DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Bank model state and expected mappings
  cfg_t  cfg_m;
  bank_t bank_m;
  rsp_t  pending_maps[$];
  rsp_t  want;
  int    mismatches;
  bit    tx_idle;
  bit    rx_idle;
  int    hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ROM bank count as the mapper sees it
  function automatic int unsigned rom_banks_in_use();
    int unsigned c;
    c = cfg_m.rom_bank_count;
    if (c < 2) c = 2;
    if (c > MaxRomBanksDefault) c = MaxRomBanksDefault;
    return c;
  endfunction

  // Predict the mapping of one bus access; register writes update the bank model
  function automatic rsp_t map_bus_access(input req_t a);
    rsp_t        r;
    int unsigned mask;
    int unsigned n;
    int unsigned rc;
    int unsigned rb;
    int unsigned off;
    logic        bit8;
    r.target          = TGT_NONE;
    r.physical_offset = '0;
    if (a.address < 16'h8000) begin
      if (a.operation == OP_WRITE) begin
        bit8 = a.address[8];
        if (cfg_m.mapper_kind == KIND_MBC1) begin
          if (a.address >= 16'h6000) bank_m.bank_mode = (a.write_data != 0);
          else if (a.address >= 16'h4000) bank_m.high_bank = a.write_data[1:0];
          else if (a.address >= 16'h2000) bank_m.low_bank = a.write_data[4:0];
          else bank_m.ram_enable = (a.write_data[3:0] == 4'hA) && (cfg_m.ram_bank_count != 0);
        end else if (cfg_m.mapper_kind == KIND_MBC2 && a.address < 16'h4000) begin
          if (a.address >= 16'h2000) begin
            if (bit8) bank_m.mbc2_bank = a.write_data[3:0];
          end else if (!bit8) begin
            bank_m.ram_enable = (a.write_data[3:0] == 4'hA);
          end
        end
      end else begin
        // switchable window: base is 0x4000 * (bank - 1)
        mask = rom_banks_in_use() - 1;
        n    = 1;
        if (cfg_m.mapper_kind == KIND_MBC1) begin
          if (bank_m.bank_mode) n = bank_m.low_bank & mask;
          else n = {bank_m.high_bank, bank_m.low_bank} & mask;
          if (n < 2) n = 1;
          else if (!bank_m.bank_mode && (n == 'h20 || n == 'h40 || n == 'h60)) n = n + 1;
        end else if (cfg_m.mapper_kind == KIND_MBC2) begin
          n = bank_m.mbc2_bank & mask;
          if (n < 2) n = 1;
        end
        r.target = TGT_ROM;
        if (a.address < 16'h4000) off = a.address;
        else off = (((n - 1) * 'h4000) & 'h1FFFFF) + a.address;
        r.physical_offset = OffsetW'(off);
      end
    end else if (a.address >= 16'hA000 && a.address < 16'hC000) begin
      if (bank_m.ram_enable) begin
        // RAM bank follows high bits only for banked MBC1 RAM in mode 1
        rc = cfg_m.ram_bank_count;
        if (rc > MaxRamBanksDefault) rc = MaxRamBanksDefault;
        rb = 0;
        if (cfg_m.mapper_kind == KIND_MBC1 && cfg_m.ram_capable && rc > 1 &&
            bank_m.bank_mode) begin
          rb = bank_m.high_bank;
          if (rb >= rc) rb = rb & (rc - 1);
        end
        off = rom_banks_in_use() * 'h4000 + rb * 'h2000 + (a.address & 16'h1FFF);
        r.target          = TGT_RAM;
        r.physical_offset = OffsetW'(off);
      end else begin
        r.target = TGT_RAM_OFF;
      end
    end
    return r;
  endfunction

  function automatic req_t access(input logic op, input logic [15:0] addr,
                                  input logic [7:0] data);
    req_t a;
    a.operation  = op;
    a.address    = addr;
    a.write_data = data;
    return a;
  endfunction

  // Offer one access (called at a falling edge); predict on the accepting edge
  task automatic send_access(input req_t a);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= a;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_maps.push_back(map_bus_access(a));
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_maps.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // One config register write; write enable is lowered by the caller
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [7:0] kind, input logic [7:0] rom_cnt,
                           input logic [7:0] ram_cnt, input logic [7:0] cap);
    write_reg(CFG_MAPPER_KIND, kind);
    write_reg(CFG_ROM_BANK_COUNT, rom_cnt);
    write_reg(CFG_RAM_BANK_COUNT, ram_cnt);
    write_reg(CFG_RAM_CAPABLE, cap);
    cfg_we_i <= 1'b0;
    cfg_m.mapper_kind    = kind[1:0];
    cfg_m.rom_bank_count = rom_cnt;
    cfg_m.ram_bank_count = ram_cnt[2:0];
    cfg_m.ram_capable    = cap[0];
  endtask

  // Reset config: plain ROM, RAM disabled, other regions unmapped
  task automatic test_plain_rom_defaults();
    send_access(access(OP_READ, 16'h0000, 8'h00));
    send_access(access(OP_READ, 16'h7FFF, 8'hFF));
    send_access(access(OP_WRITE, 16'h2000, 8'h05));
    send_access(access(OP_READ, 16'h4000, 8'h00));
    send_access(access(OP_READ, 16'hA000, 8'h00));
    send_access(access(OP_READ, 16'h9FFF, 8'h00));
    send_access(access(OP_WRITE, 16'hFFFF, 8'hFF));
  endtask

  // MBC1: RAM enable, bank quirk, both banking modes
  task automatic test_mbc1_banking();
    settle();
    configure(KIND_MBC1, 8'd128, 8'd4, 8'd1);
    send_access(access(OP_WRITE, 16'h0000, 8'h0A));
    send_access(access(OP_READ, 16'hA000, 8'h00));
    send_access(access(OP_WRITE, 16'h4000, 8'h01));  // 0x20 -> 0x21
    send_access(access(OP_READ, 16'h4000, 8'h00));
    send_access(access(OP_WRITE, 16'h2000, 8'hFF));
    send_access(access(OP_READ, 16'h7FFF, 8'h00));
    send_access(access(OP_WRITE, 16'h5FFF, 8'hFF));
    send_access(access(OP_WRITE, 16'h3FFF, 8'h00));  // 0x60 -> 0x61
    send_access(access(OP_READ, 16'h5555, 8'h00));
    send_access(access(OP_WRITE, 16'h6000, 8'h01));  // mode 1: RAM bank from high bits
    send_access(access(OP_WRITE, 16'hBFFF, 8'h5A));
    send_access(access(OP_READ, 16'h4000, 8'h00));
    send_access(access(OP_WRITE, 16'h7FFF, 8'h00));
    send_access(access(OP_WRITE, 16'h1FFF, 8'hF0));  // disable RAM
    send_access(access(OP_READ, 16'hA123, 8'h00));
  endtask

  // MBC2: address bit 8 steers enable vs bank writes
  task automatic test_mbc2_banking();
    settle();
    configure(KIND_MBC2, 8'd16, 8'd0, 8'd0);
    send_access(access(OP_WRITE, 16'h0000, 8'hFA));
    send_access(access(OP_WRITE, 16'h0100, 8'h00));  // ignored, bit 8 set
    send_access(access(OP_READ, 16'hA010, 8'h00));
    send_access(access(OP_WRITE, 16'h2100, 8'hFF));
    send_access(access(OP_READ, 16'h4000, 8'h00));
    send_access(access(OP_WRITE, 16'h2000, 8'h05));  // ignored, bit 8 clear
    send_access(access(OP_READ, 16'h7FFF, 8'h00));
  endtask

  // Unused mapper kind and out-of-range bank counts
  task automatic test_unused_kind_and_odd_counts();
    settle();
    configure(8'd3, 8'd0, 8'd7, 8'd1);
    send_access(access(OP_READ, 16'h4000, 8'h00));
    send_access(access(OP_READ, 16'hBFFF, 8'h00));
  endtask

  // Long receiver stall while the sender keeps offering back to back
  task automatic test_output_stall();
    int i;
    settle();
    configure(KIND_MBC1, 8'd128, 8'd4, 8'd1);
    tx_idle     = 1'b0;
    hold_cycles = 80;
    for (i = 0; i < 40; i++)
      send_access(access(i[0], 16'($urandom_range(0, 16'h7FFF)), 8'($urandom)));
    tx_idle = 1'b1;
  endtask

  // Random phases: bank-register writes mixed with ROM, RAM and random accesses
  task automatic test_random_traffic();
    int   p;
    int   i;
    int   pick;
    req_t a;
    for (p = 0; p < 12; p++) begin
      settle();
      case (p)
        0:       configure(KIND_MBC1, 8'd128, 8'd4, 8'd1);
        1:       configure(KIND_MBC1, 8'd2, 8'd0, 8'd0);
        2:       configure(KIND_MBC1, 8'd255, 8'd7, 8'd1);
        3:       configure(KIND_MBC2, 8'd128, 8'd4, 8'd0);
        4:       configure(KIND_MBC2, 8'd2, 8'd1, 8'd1);
        5:       configure(KIND_PLAIN, 8'd1, 8'd0, 8'd0);
        6:       configure(8'd3, 8'd3, 8'd2, 8'd1);
        7:       configure(KIND_MBC1, 8'd64, 8'd3, 8'd1);
        8, 9:    configure(8'($urandom_range(1, 2)), 8'(1 << $urandom_range(1, 7)),
                           8'($urandom_range(0, 4)), 8'($urandom_range(0, 1)));
        default: configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      tx_idle = (p % 4 == 0) || (p % 4 == 2);
      rx_idle = (p % 4 == 0) || (p % 4 == 3);
      for (i = 0; i < 100; i++) begin
        pick         = $urandom_range(0, 99);
        a.operation  = OP_READ;
        a.address    = '0;
        a.write_data = 8'($urandom);
        if (pick < 30) begin
          a.operation = OP_WRITE;
          a.address   = 16'($urandom_range(0, 3) * 'h2000 + $urandom_range(0, 'h1FFF));
          if (a.address < 16'h2000 && $urandom_range(0, 1)) a.write_data[3:0] = 4'hA;
          if (a.address >= 16'h6000 && $urandom_range(0, 1)) a.write_data = '0;
        end else if (pick < 60) begin
          a.address = 16'($urandom_range(0, 'h7FFF));
        end else if (pick < 85) begin
          a.operation = 1'($urandom_range(0, 1));
          a.address   = 16'($urandom_range('hA000, 'hBFFF));
        end else begin
          a.operation = 1'($urandom_range(0, 1));
          a.address   = 16'($urandom);
        end
        send_access(a);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result side: random stalls per transaction, plus a requested hold-off
  initial begin : result_ready_driver
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual target %0d offset %h",
                 $time, rsp_if.payload.target, rsp_if.payload.physical_offset);
        mismatches++;
      end else begin
        want = pending_maps.pop_front();
        if (rsp_if.payload.target !== want.target) begin
          $display("%0t: target expected %0d actual %0d", $time, want.target,
                   rsp_if.payload.target);
          mismatches++;
        end
        if (rsp_if.payload.physical_offset !== want.physical_offset) begin
          $display("%0t: physical_offset expected %h actual %h", $time,
                   want.physical_offset, rsp_if.payload.physical_offset);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAPPER_KIND;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    cfg_m          = '{mapper_kind: KIND_PLAIN, rom_bank_count: 8'd2,
                       ram_bank_count: 3'd0, ram_capable: 1'b0};
    bank_m         = '0;
    mismatches     = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    hold_cycles    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_plain_rom_defaults();
    test_mbc1_banking();
    test_mbc2_banking();
    test_unused_kind_and_odd_counts();
    test_output_stall();
    test_random_traffic();

    settle();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
